// ===== hw/rtl/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Escape handling constants, header layout, result codes and the
// check field size function.
// ----------------------------------------------------------------------------
package efd_pkg;

    // Stuffing
    localparam logic [7:0] ESC_CODE = 8'h1B;
    localparam logic [7:0] ESC_MASK = 8'h20;

    // Header layout in unstuffed bytes
    localparam int unsigned HDR_BYTES  = 13;
    localparam int unsigned CNT_W      = 17;
    localparam logic [CNT_W-1:0] POS_SENDER   = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_RECEIVER = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_STAMP    = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_SEQ      = CNT_W'(10);
    localparam logic [CNT_W-1:0] POS_LEN_HI   = CNT_W'(11);
    localparam logic [CNT_W-1:0] POS_LEN_LO   = CNT_W'(12);
    localparam logic [CNT_W-1:0] POS_HDR_END  = CNT_W'(HDR_BYTES);

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CHECK   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Frame status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TRUNCATED = 2'd1;
    localparam logic [1:0] STAT_ESC_END   = 2'd2;

    // Largest payload lengths that still fit a 1-byte and a 2-byte check
    // field (parity count p at most 7, at most 15).
    localparam logic [15:0] CHK1_MAX_LEN = 16'd15;
    localparam logic [15:0] CHK2_MAX_LEN = 16'd4094;

    // Output payload widths
    localparam int unsigned TDATA_W = 120;
    localparam int unsigned TUSER_W = 2;

    // One result item
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  out_byte;
        logic [7:0]  sender_id;
        logic [7:0]  receiver_id;
        logic [63:0] time_stamp;
        logic [7:0]  sequence_number;
        logic [15:0] payload_length;
        logic [1:0]  frame_status;
    } efd_result_t;

    // Check field size in bytes, (p+8)/8 for the Hamming parity count p
    function automatic logic [1:0] check_size(input logic [15:0] len);
        logic [1:0] size;
        if (len <= CHK1_MAX_LEN) begin
            size = 2'd1;
        end else if (len <= CHK2_MAX_LEN) begin
            size = 2'd2;
        end else begin
            size = 2'd3;
        end
        return size;
    endfunction

endpackage

// ===== hw/rtl/efd_parse.sv =====
// ----------------------------------------------------------------------------
// efd_parse: unstuffing and header parsing
// Holds the per-frame state, removes escapes and turns each accepted raw
// byte into at most one result item in the same cycle.
// ----------------------------------------------------------------------------
module efd_parse
    import efd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,         // a raw byte transaction is accepted
    input  logic [7:0]  byte_value,
    input  logic        frame_end,
    output logic        res_valid,
    output efd_result_t res
);

    logic             awaiting_reg, awaiting_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sender_reg, sender_next;
    logic [7:0]       receiver_reg, receiver_next;
    logic [63:0]      stamp_reg, stamp_next;
    logic [7:0]       sequence_reg, sequence_next;
    logic [15:0]      length_reg, length_next;
    logic [1:0]       check_reg, check_next;

    logic [7:0]       unstuffed;
    logic             data_byte;
    logic             in_header;
    logic [CNT_W-1:0] pay_end;
    logic [CNT_W-1:0] all_end;
    logic             in_body;
    logic [15:0]      full_len;

    // Decode of the current byte
    assign unstuffed = esc_reg ? (byte_value ^ ESC_MASK) : byte_value;
    assign data_byte = !frame_end && !awaiting_reg && (esc_reg || (byte_value != ESC_CODE));
    assign in_header = (count_reg < POS_HDR_END);
    assign pay_end   = POS_HDR_END + CNT_W'(length_reg);
    assign all_end   = pay_end + CNT_W'(check_reg);
    assign in_body   = !in_header && (count_reg < all_end);
    assign full_len  = {length_reg[15:8], unstuffed};

    // Next state
    always_comb begin
        awaiting_next = awaiting_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        sender_next   = sender_reg;
        receiver_next = receiver_reg;
        stamp_next    = stamp_reg;
        sequence_next = sequence_reg;
        length_next   = length_reg;
        check_next    = check_reg;
        if (frame_end) begin
            awaiting_next = 1'b1;
            esc_next      = 1'b0;
            count_next    = '0;
            sender_next   = '0;
            receiver_next = '0;
            stamp_next    = '0;
            sequence_next = '0;
            length_next   = '0;
            check_next    = '0;
        end else if (awaiting_reg) begin
            // start flag dropped
            awaiting_next = 1'b0;
        end else if (!esc_reg && (byte_value == ESC_CODE)) begin
            esc_next = 1'b1;
        end else begin
            esc_next = 1'b0;
            if (in_header) begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg == POS_SENDER) begin
                    sender_next = unstuffed;
                end else if (count_reg == POS_RECEIVER) begin
                    receiver_next = unstuffed;
                end else if (count_reg < POS_SEQ) begin
                    // little-endian stamp, one lane per position
                    for (int i = 0; i < 8; i++) begin
                        if (count_reg == POS_STAMP + CNT_W'(i)) begin
                            stamp_next[i*8 +: 8] = unstuffed;
                        end
                    end
                end else if (count_reg == POS_SEQ) begin
                    sequence_next = unstuffed;
                end else if (count_reg == POS_LEN_HI) begin
                    length_next = {unstuffed, 8'h00};
                end else begin
                    length_next = full_len;
                    check_next  = check_size(full_len);
                end
            end else if (in_body) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Result for the current byte
    always_comb begin
        res       = '0;
        res_valid = 1'b0;
        if (frame_end) begin
            res_valid           = 1'b1;
            res.item_kind       = KIND_SUMMARY;
            res.sender_id       = sender_reg;
            res.receiver_id     = receiver_reg;
            res.time_stamp      = stamp_reg;
            res.sequence_number = sequence_reg;
            res.payload_length  = length_reg;
            if (awaiting_reg) begin
                res.frame_status = STAT_TRUNCATED;
            end else if (esc_reg) begin
                res.frame_status = STAT_ESC_END;
            end else if (in_header || (count_reg < all_end)) begin
                res.frame_status = STAT_TRUNCATED;
            end else begin
                res.frame_status = STAT_OK;
            end
        end else if (data_byte && in_body) begin
            res_valid     = 1'b1;
            res.item_kind = (count_reg < pay_end) ? KIND_PAYLOAD : KIND_CHECK;
            res.out_byte  = unstuffed;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b1;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            sender_reg   <= '0;
            receiver_reg <= '0;
            stamp_reg    <= '0;
            sequence_reg <= '0;
            length_reg   <= '0;
            check_reg    <= '0;
        end else if (take) begin
            awaiting_reg <= awaiting_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            sender_reg   <= sender_next;
            receiver_reg <= receiver_next;
            stamp_reg    <= stamp_next;
            sequence_reg <= sequence_next;
            length_reg   <= length_next;
            check_reg    <= check_next;
        end
    end

endmodule

// ===== hw/rtl/escaped_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_deframer_unit: byte-stuffed frame deframer
// Results are registered: each shows on m_tvalid in the cycle after its input.
// Throughput: one raw byte per cycle unless m_tready stalls; the output register
// refills in the cycle it is drained, so input and output run back to back.
// Reset: synchronous, active low; clears the frame state (awaiting start flag)
// and empties the output register.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_unit
    import efd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // raw byte stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] byte_value
    input  logic               s_tlast,    // frame_end
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,    // [7:0] out_byte, [15:8] sender_id,
                                           // [23:16] receiver_id, [87:24] time_stamp,
                                           // [95:88] sequence_number,
                                           // [111:96] payload_length,
                                           // [113:112] frame_status, rest zero
    output logic [TUSER_W-1:0] m_tuser     // [1:0] item_kind
);

    logic               take;
    logic               res_valid;
    efd_result_t        res;
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;
    logic [TUSER_W-1:0] m_user_reg;

    // Input is taken whenever the output register is free or drains now
    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    efd_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .byte_value (s_tdata),
        .frame_end  (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            m_data_reg <= {6'd0, res.frame_status, res.payload_length,
                           res.sequence_number, res.time_stamp, res.receiver_id,
                           res.sender_id, res.out_byte};
            m_user_reg <= res.item_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
